// ===== rtl/radix_string_to_integer_assert.svh =====
// Assertion macros shared by the radix string-to-integer RTL.
`ifndef RADIX_STRING_TO_INTEGER_ASSERT_SVH
`define RADIX_STRING_TO_INTEGER_ASSERT_SVH
`ifndef SYNTH
// Property checked on every clock edge outside reset.
`define RSTOI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// A condition in one cycle implies a consequence in the next.
`define RSTOI_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) else $error(msg);
`else
`define RSTOI_ASSERT(lbl, prop, msg)
`define RSTOI_ASSERT_NEXT(lbl, cond, cons, msg)
`endif
`endif

// ===== rtl/rstoi_pkg.sv =====
// Shared constants and types of the radix string-to-integer converter.
package rstoi_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int OUT_BITS    = 32;
  localparam int DIGIT_BITS  = 7;
  localparam int SYM_BITS    = 8;
  localparam int MAP_DEPTH   = 256;
  localparam int SIZE_MAX    = 127;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] ACT_NEW    = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_CHAR   = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  localparam logic [1:0] PH_SKIP   = 2'd0;
  localparam logic [1:0] PH_SIGN   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_STOP   = 2'd3;

  localparam logic [SYM_BITS-1:0] CH_NUL   = 8'h00;
  localparam logic [SYM_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [SYM_BITS-1:0] CH_LF    = 8'h0A;
  localparam logic [SYM_BITS-1:0] CH_VT    = 8'h0B;
  localparam logic [SYM_BITS-1:0] CH_FF    = 8'h0C;
  localparam logic [SYM_BITS-1:0] CH_CR    = 8'h0D;
  localparam logic [SYM_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [SYM_BITS-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_BITS-1:0] CH_TILDE = 8'h7E;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_TERM,
    KIND_ABORT
  } kind_e;

  // One classified transaction on its way from the front to the back.
  typedef struct packed {
    kind_e                 kind;
    logic                  is_space;
    logic                  is_plus;
    logic                  is_minus;
    logic                  hit;
    logic [DIGIT_BITS-1:0] digit;
    logic [DIGIT_BITS-1:0] size;
    logic                  ok;
  } entry_t;

endpackage

// ===== rtl/rstoi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rstoi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rstoi_front.sv =====
// Front end: accepts transactions, maintains the alphabet and classifies characters.
`include "radix_string_to_integer_assert.svh"
module rstoi_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         action_i,
  input  logic [rstoi_pkg::SYM_BITS-1:0]     symbol_i,
  input  logic                               q_full_i,
  output logic                               q_push_o,
  output rstoi_pkg::entry_t                  q_entry_o
);

  logic                                   accept;
  logic                                   is_new;
  logic                                   is_app;
  logic                                   is_chr;
  logic                                   sym_legal;
  logic                                   hit_now;
  logic [rstoi_pkg::MAP_DEPTH-1:0]        map_valid_q, map_valid_d;
  logic [rstoi_pkg::DIGIT_BITS-1:0]       size_q, size_d;
  logic                                   err_q, err_d;
  logic                                   ram_we;
  logic [rstoi_pkg::DIGIT_BITS-1:0]       ram_wdata;
  logic [rstoi_pkg::DIGIT_BITS-1:0]       ram_rdata;
  logic                                   s1_load;
  logic                                   s1_valid_q, s1_valid_d;
  rstoi_pkg::entry_t                      s1_q, s1_d;

  assign accept = in_valid_i && !in_stall_o;
  assign is_new = accept && (action_i == rstoi_pkg::ACT_NEW);
  assign is_app = accept && (action_i == rstoi_pkg::ACT_APPEND);
  assign is_chr = accept && (action_i == rstoi_pkg::ACT_CHAR);

  // Printable, not a space, and neither sign character.
  assign sym_legal = (symbol_i > rstoi_pkg::CH_SPACE) && (symbol_i <= rstoi_pkg::CH_TILDE)
                     && (symbol_i != rstoi_pkg::CH_PLUS) && (symbol_i != rstoi_pkg::CH_MINUS);
  assign hit_now = map_valid_q[symbol_i];

  always_comb begin
    map_valid_d = map_valid_q;
    size_d      = size_q;
    err_d       = err_q;
    ram_we      = 1'b0;
    ram_wdata   = size_q;
    if (is_new) begin
      map_valid_d = '0;
      size_d      = '0;
      err_d       = 1'b0;
      ram_wdata   = '0;
      if (sym_legal) begin
        map_valid_d[symbol_i] = 1'b1;
        size_d                = rstoi_pkg::DIGIT_BITS'(1);
        ram_we                = 1'b1;
      end else begin
        err_d = 1'b1;
      end
    end else if (is_app) begin
      if (!sym_legal || hit_now) begin
        err_d = 1'b1;
      end else begin
        map_valid_d[symbol_i] = 1'b1;
        ram_we                = 1'b1;
        if (size_q != rstoi_pkg::DIGIT_BITS'(rstoi_pkg::SIZE_MAX)) begin
          size_d = size_q + rstoi_pkg::DIGIT_BITS'(1);
        end
      end
    end
  end

  rstoi_ram #(
    .WIDTH(rstoi_pkg::DIGIT_BITS),
    .DEPTH(rstoi_pkg::MAP_DEPTH)
  ) u_digit_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(symbol_i),
    .wdata_i(ram_wdata),
    .re_i   (is_chr),
    .raddr_i(symbol_i),
    .rdata_o(ram_rdata)
  );

  // The lookup stage holds a transaction while its digit comes out of the RAM.
  assign s1_load = is_new || is_chr;

  always_comb begin
    s1_d          = s1_q;
    s1_d.is_space = (symbol_i == rstoi_pkg::CH_SPACE) || (symbol_i == rstoi_pkg::CH_TAB)
                    || (symbol_i == rstoi_pkg::CH_LF) || (symbol_i == rstoi_pkg::CH_VT)
                    || (symbol_i == rstoi_pkg::CH_FF) || (symbol_i == rstoi_pkg::CH_CR);
    s1_d.is_plus  = (symbol_i == rstoi_pkg::CH_PLUS);
    s1_d.is_minus = (symbol_i == rstoi_pkg::CH_MINUS);
    s1_d.hit      = hit_now;
    s1_d.digit    = '0;
    s1_d.size     = size_q;
    s1_d.ok       = !err_q && (size_q >= rstoi_pkg::DIGIT_BITS'(2));
    if (action_i == rstoi_pkg::ACT_NEW) begin
      s1_d.kind = rstoi_pkg::KIND_ABORT;
    end else if (symbol_i == rstoi_pkg::CH_NUL) begin
      s1_d.kind = rstoi_pkg::KIND_TERM;
    end else begin
      s1_d.kind = rstoi_pkg::KIND_CHAR;
    end
  end

  assign q_push_o   = s1_valid_q && !q_full_i;
  assign in_stall_o = s1_valid_q && q_full_i;
  assign s1_valid_d = s1_load ? 1'b1 : (q_push_o ? 1'b0 : s1_valid_q);

  always_comb begin
    q_entry_o       = s1_q;
    q_entry_o.digit = ram_rdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_valid_q <= '0;
      size_q      <= '0;
      err_q       <= 1'b0;
      s1_valid_q  <= 1'b0;
    end else begin
      map_valid_q <= map_valid_d;
      size_q      <= size_d;
      err_q       <= err_d;
      s1_valid_q  <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_q <= s1_d;
    end
  end

  `RSTOI_ASSERT_NEXT(a_new_alphabet, is_new, (size_q == rstoi_pkg::DIGIT_BITS'(1)) != err_q, "new alphabet left inconsistent size and error")
  `RSTOI_ASSERT(a_no_lookup_when_held, (s1_valid_q && q_full_i) |-> !is_chr, "digit lookup issued while lookup stage is held")

endmodule

// ===== rtl/rstoi_queue.sv =====
// Short queue of classified transactions between the front and the back.
`include "radix_string_to_integer_assert.svh"
module rstoi_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rstoi_pkg::entry_t entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output rstoi_pkg::entry_t entry_o
);

  rstoi_pkg::entry_t               slot_q [rstoi_pkg::QUEUE_DEPTH];
  logic [rstoi_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [rstoi_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [rstoi_pkg::QCNT_W-1:0]    count_q, count_d;

  assign full_o  = (count_q == rstoi_pkg::QCNT_W'(rstoi_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == rstoi_pkg::QPTR_W'(rstoi_pkg::QUEUE_DEPTH - 1))
                 ? '0 : wr_ptr_q + rstoi_pkg::QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == rstoi_pkg::QPTR_W'(rstoi_pkg::QUEUE_DEPTH - 1))
                 ? '0 : rd_ptr_q + rstoi_pkg::QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + rstoi_pkg::QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - rstoi_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  `RSTOI_ASSERT(a_no_push_full, !(push_i && full_o), "push into a full queue")
  `RSTOI_ASSERT(a_no_pop_empty, !(pop_i && !valid_o), "pop from an empty queue")
  `RSTOI_ASSERT(a_count_bound, count_q <= rstoi_pkg::QCNT_W'(rstoi_pkg::QUEUE_DEPTH), "queue count beyond depth")

endmodule

// ===== rtl/rstoi_back.sv =====
// Back end: sign and digit parsing, accumulation and the result register.
`include "radix_string_to_integer_assert.svh"
module rstoi_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  q_valid_i,
  input  rstoi_pkg::entry_t                     q_entry_i,
  output logic                                  q_pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [rstoi_pkg::OUT_BITS-1:0] value_o,
  output logic                                  base_valid_o
);

  logic [1:0]                             phase_q, phase_d;
  logic                                   neg_q, neg_d;
  logic [rstoi_pkg::VALUE_BITS-1:0]       acc_q, acc_d;
  logic                                   out_valid_q, out_valid_d;
  logic signed [rstoi_pkg::OUT_BITS-1:0]  value_q;
  logic                                   base_valid_q;
  logic                                   take_out;
  logic                                   is_term;
  logic                                   load_out;
  logic [rstoi_pkg::VALUE_BITS-1:0]       acc_step;
  logic [rstoi_pkg::VALUE_BITS-1:0]       acc_signed;
  logic signed [rstoi_pkg::OUT_BITS-1:0]  term_value;

  assign take_out = !out_valid_q || !out_stall_i;
  assign is_term  = (q_entry_i.kind == rstoi_pkg::KIND_TERM);
  assign q_pop_o  = q_valid_i && (!is_term || take_out);
  assign load_out = q_pop_o && is_term;

  // One multiply-accumulate per digit, wrapped to the accumulator width.
  assign acc_step = rstoi_pkg::VALUE_BITS'(
                      acc_q * rstoi_pkg::VALUE_BITS'(q_entry_i.size)
                      + rstoi_pkg::VALUE_BITS'(q_entry_i.digit));

  assign acc_signed = neg_q ? (rstoi_pkg::VALUE_BITS'(0) - acc_q) : acc_q;
  assign term_value = q_entry_i.ok
                      ? rstoi_pkg::OUT_BITS'($signed(acc_signed))
                      : '0;

  always_comb begin
    logic [1:0] eff;
    eff     = phase_q;
    phase_d = phase_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    if (q_pop_o) begin
      case (q_entry_i.kind)
        rstoi_pkg::KIND_CHAR: begin
          // Leading phases fall through as soon as the character does not belong to them.
          if (eff == rstoi_pkg::PH_SKIP && !q_entry_i.is_space) begin
            eff = rstoi_pkg::PH_SIGN;
          end
          if (eff == rstoi_pkg::PH_SIGN && !q_entry_i.is_plus && !q_entry_i.is_minus) begin
            eff = rstoi_pkg::PH_DIGITS;
          end
          phase_d = eff;
          if (eff == rstoi_pkg::PH_SIGN && q_entry_i.is_minus) begin
            neg_d = !neg_q;
          end
          if (eff == rstoi_pkg::PH_DIGITS) begin
            if (q_entry_i.hit) begin
              acc_d = acc_step;
            end else begin
              phase_d = rstoi_pkg::PH_STOP;
            end
          end
        end
        rstoi_pkg::KIND_TERM, rstoi_pkg::KIND_ABORT: begin
          phase_d = rstoi_pkg::PH_SKIP;
          neg_d   = 1'b0;
          acc_d   = '0;
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= rstoi_pkg::PH_SKIP;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      value_q      <= term_value;
      base_valid_q <= q_entry_i.ok;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign base_valid_o = base_valid_q;

  `RSTOI_ASSERT_NEXT(a_bad_alphabet_zero, load_out && !q_entry_i.ok, (value_q == '0) && !base_valid_q, "invalid alphabet produced a nonzero result")
  `RSTOI_ASSERT_NEXT(a_abort_clears, q_valid_i && (q_entry_i.kind == rstoi_pkg::KIND_ABORT), (phase_q == rstoi_pkg::PH_SKIP) && !neg_q && (acc_q == '0), "abort did not clear the parse")

endmodule

// ===== rtl/radix_string_to_integer.sv =====
// Top level of the radix string-to-integer converter.
//
//   Channel  Dir  Handshake                  Payload
//   in       in   in_valid_i / in_stall_o    action_i, symbol_i
//   out      out  out_valid_o / out_stall_i  value_o, base_valid_o
//
// One transaction per cycle sustained while in_stall_o stays low; the digit-map
// RAM read is registered and the back end does one multiply-accumulate per character.
// A terminator passes the lookup stage and the queue before its result is loaded
// into the result register and out_valid_o rises.
// Reset and a new-alphabet transaction clear the 256 symbol valid flags at once.
// A two-entry queue and the lookup stage absorb output stalls; in_stall_o rises
// only when the lookup stage holds a transaction and the queue is full.
module radix_string_to_integer (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [1:0]                            action_i,
  input  logic [rstoi_pkg::SYM_BITS-1:0]        symbol_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [rstoi_pkg::OUT_BITS-1:0] value_o,
  output logic                                  base_valid_o
);

  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  rstoi_pkg::entry_t push_entry;
  rstoi_pkg::entry_t head_entry;

  rstoi_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .action_i  (action_i),
    .symbol_i  (symbol_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_entry_o (push_entry)
  );

  rstoi_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(push_entry),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .entry_o(head_entry)
  );

  rstoi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (head_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .base_valid_o(base_valid_o)
  );

endmodule
